[design/ftrg_pkg.sv]
// ----------------------------------------------------------------------------
// ftrg_pkg: shared types and constants
// Field structs, controller state, command and status bundles, tier helpers.
// ----------------------------------------------------------------------------
package ftrg_pkg;

	localparam int LongWindow  = 32;
	localparam int ShortWindow = 8;
	localparam int TierLimit   = 3;
	localparam int PtrW        = $clog2(LongWindow);
	localparam int FillW       = $clog2(LongWindow + 1);
	localparam int CntW        = $clog2(LongWindow + 1);

	localparam logic [1:0] ActSample = 2'd0;
	localparam logic [1:0] ActApply  = 2'd1;
	localparam logic [1:0] ActClear  = 2'd2;

	localparam logic [1:0] RegBaseW  = 2'd0;
	localparam logic [1:0] RegBaseH  = 2'd1;
	localparam logic [1:0] RegDownTh = 2'd2;
	localparam logic [1:0] RegUpTh   = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] frame_time;
		logic [1:0]  requested_tier;
	} in_item_t;

	typedef struct packed {
		logic        switch_wanted;
		logic [1:0]  proposed_tier;
		logic [22:0] window_p95;
		logic        apply_ok;
		logic [1:0]  active_tier;
		logic [1:0]  tiers_available;
		logic [15:0] active_width;
		logic [15:0] active_height;
		logic [31:0] switches_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SEL_INIT,
		ST_SEL_READ,
		ST_SEL_CMP,
		ST_DECIDE,
		ST_OUT
	} ctl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic do_write;
		logic do_apply;
		logic do_clear;
		logic sel_start;
		logic sel_long;
		logic sel_read;
		logic sel_cmp;
		logic decide;
		logic out_load;
	} ftrg_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic       try_short;
		logic       try_long;
		logic       sel_done;
		logic       sel_found;
		logic       short_fired;
	} ftrg_sts_t;

	// round(b*num/den), den = 4 or 2, clamped to 1..65535
	function automatic logic [15:0] scale34(input logic [15:0] b);
		logic [18:0] s;
		s = ({3'd0, b} * 19'd3 + 19'd2) >> 2;
		if (s == 19'd0) return 16'd1;
		if (s > 19'd65535) return 16'hFFFF;
		return s[15:0];
	endfunction

	function automatic logic [15:0] scale12(input logic [15:0] b);
		logic [16:0] s;
		s = ({1'b0, b} + 17'd1) >> 1;
		if (s == 17'd0) return 16'd1;
		if (s > 17'd65535) return 16'hFFFF;
		return s[15:0];
	endfunction

	function automatic logic [CntW-1:0] pct_rank(input int n);
		int r;
		r = (95 * n + 99) / 100;
		if (r < 1) r = 1;
		if (r > n) r = n;
		return CntW'(r);
	endfunction

endpackage

[design/frame_time_resolution_governor.sv]
// ----------------------------------------------------------------------------
// frame_time_resolution_governor: dynamic resolution scaling governor
// Apply, clear and ignored items go from accept through the write and output
// states with no selection. A sample adds up to two rank selections, short
// window first, each with a read and a compare step per scanned element and
// a capture read and compare step per candidate.
// One item in flight. Reset clears all control state; the ring needs no clearing.
// ----------------------------------------------------------------------------
module frame_time_resolution_governor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ftrg_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ftrg_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ftrg_pkg::*;

	ftrg_cmd_t cmd;
	ftrg_sts_t sts;

	assign cfg_ready = 1'b1;

	ftrg_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall,
		.out_full(out_valid && out_stall),
		.sts, .cmd
	);

	ftrg_datapath u_dp (
		.clk, .arst_n, .in_data,
		.cfg_we(cfg_valid), .cfg_index, .cfg_data,
		.cmd, .sts, .out_stall, .out_valid, .out_data
	);
endmodule

[design/ftrg_ctrl.sv]
// ----------------------------------------------------------------------------
// ftrg_ctrl: sequencing controller
// Steps one item through write, percentile selection passes and output.
// ----------------------------------------------------------------------------
module ftrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_full,
	input  ftrg_pkg::ftrg_sts_t sts,
	output ftrg_pkg::ftrg_cmd_t cmd
);
	import ftrg_pkg::*;

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (sts.action == ActSample) begin
					cmd.do_write = 1'b1;
					state_d = ST_SEL_INIT;
				end else begin
					cmd.do_apply = (sts.action == ActApply);
					cmd.do_clear = (sts.action == ActClear);
					state_d = ST_OUT;
				end
			end
			ST_SEL_INIT: begin
				// short pass first, long pass if the short pass wanted no switch
				if (sts.try_short && !sts.short_fired) begin
					cmd.sel_start = 1'b1;
					state_d = ST_SEL_READ;
				end else if (sts.try_long) begin
					cmd.sel_start = 1'b1;
					cmd.sel_long  = 1'b1;
					state_d = ST_SEL_READ;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SEL_READ: begin
				cmd.sel_read = 1'b1;
				state_d = ST_SEL_CMP;
			end
			ST_SEL_CMP: begin
				cmd.sel_cmp = 1'b1;
				if (sts.sel_done) state_d = ST_DECIDE;
				else state_d = ST_SEL_READ;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = ST_SEL_INIT;
			end
			ST_OUT: begin
				if (!out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// a selection pass only starts from the init state
	a_start_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_start |-> state_q == ST_SEL_INIT)
		else $error("selection started outside init");
	// no new item while busy
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input open while busy");
	// compare always follows a read
	a_read_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_read |=> state_q == ST_SEL_CMP)
		else $error("read not followed by compare");
endmodule

[design/ftrg_datapath.sv]
// ----------------------------------------------------------------------------
// ftrg_datapath: ring, tier table, rank selection and result register
// Selection finds the rank-k value by counting, with a read step before each comparison.
// ----------------------------------------------------------------------------
module ftrg_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ftrg_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  ftrg_pkg::ftrg_cmd_t  cmd,
	output ftrg_pkg::ftrg_sts_t  sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output ftrg_pkg::out_item_t  out_data
);
	import ftrg_pkg::*;

	logic [22:0] ring_q [LongWindow];
	logic [22:0] rd_q;
	in_item_t    item_q;
	logic [PtrW-1:0]  cursor_q;
	logic [FillW-1:0] fill_q;
	logic [1:0]  tier_q, count_q;
	logic [31:0] switch_q;
	logic [15:0] bw_q, bh_q;
	logic [22:0] down_q, up_q;
	logic [15:0] tw_q [TierLimit];
	logic [15:0] th_q [TierLimit];

	// selection state
	logic            long_q;
	logic [PtrW-1:0] cand_q, scan_q;
	logic [CntW-1:0] scan_n_q, lt_q, le_q;
	logic [22:0]     cval_q, pct_q;
	logic            found_q, want_q, fired_q;
	logic [1:0]      prop_q;
	logic            phase_cap_q;

	logic [CntW-1:0] win_n, rank;
	logic [PtrW-1:0] win_base, rd_addr;
	logic            last_scan;
	logic [CntW-1:0] lt_n, le_n;
	logic [15:0]     w0, h0, w1, h1, w2, h2;
	logic            keep1, keep2;
	logic [1:0]      t_clip;
	logic            can_down, can_up;

	assign win_n    = long_q ? CntW'(LongWindow) : CntW'(ShortWindow);
	assign rank     = long_q ? pct_rank(LongWindow) : pct_rank(ShortWindow);
	assign win_base = cursor_q - win_n[PtrW-1:0];
	assign last_scan = (scan_n_q == win_n - CntW'(1));
	// candidate fetch during capture phase, scan element otherwise
	assign rd_addr  = phase_cap_q ? cand_q : scan_q;

	// tier derivation from base size
	assign w0 = (bw_q == '0) ? 16'd1 : bw_q;
	assign h0 = (bh_q == '0) ? 16'd1 : bh_q;
	assign w1 = scale34(w0);
	assign h1 = scale34(h0);
	assign w2 = scale12(w0);
	assign h2 = scale12(h0);
	assign keep1 = (w1 != w0) || (h1 != h0);
	assign keep2 = keep1 ? ((w2 != w1) || (h2 != h1)) : ((w2 != w0) || (h2 != h0));

	assign can_down = ({1'b0, tier_q} + 3'd1) < {1'b0, count_q};
	assign can_up   = tier_q != 2'd0;

	always_comb begin
		sts.action      = item_q.action;
		sts.try_short   = can_down && (fill_q >= FillW'(ShortWindow))
			&& (ShortWindow <= LongWindow) && !long_q;
		sts.try_long    = can_up && (fill_q >= FillW'(LongWindow)) && !want_q
			&& !long_q;
		sts.sel_done    = found_q;
		sts.sel_found   = found_q;
		sts.short_fired = fired_q;
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.do_write) ring_q[cursor_q] <= item_q.frame_time[23] ? 23'd0 :
			item_q.frame_time[22:0];
		rd_q <= ring_q[rd_addr];
	end

	// comparison counts for the current candidate
	always_comb begin
		lt_n = lt_q + CntW'(rd_q < cval_q);
		le_n = le_q + CntW'(rd_q <= cval_q);
	end

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			fill_q   <= '0;
			tier_q   <= '0;
			count_q  <= 2'd3;
			switch_q <= '0;
			bw_q     <= 16'd320;
			bh_q     <= 16'd240;
			down_q   <= 23'd8533;
			up_q     <= 23'd5120;
			tw_q[0]  <= 16'd320; th_q[0] <= 16'd240;
			tw_q[1]  <= 16'd240; th_q[1] <= 16'd180;
			tw_q[2]  <= 16'd160; th_q[2] <= 16'd120;
			out_valid <= 1'b0;
			long_q   <= 1'b0;
			want_q   <= 1'b0;
			fired_q  <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					RegBaseW:  bw_q <= cfg_data[15:0];
					RegBaseH:  bh_q <= cfg_data[15:0];
					RegDownTh: down_q <= cfg_data[22:0];
					RegUpTh:   up_q <= cfg_data[22:0];
					default: ;
				endcase
				if (cfg_index == RegBaseW || cfg_index == RegBaseH) begin
					tier_q <= '0; switch_q <= '0; cursor_q <= '0; fill_q <= '0;
				end
			end else begin
				// refresh tier table from registered base size
				tw_q[0] <= w0; th_q[0] <= h0;
				tw_q[1] <= keep1 ? w1 : w2; th_q[1] <= keep1 ? h1 : h2;
				tw_q[2] <= w2; th_q[2] <= h2;
				count_q <= 2'd1 + 2'(keep1) + 2'(keep2);
			end
			if (cmd.load_item) begin
				want_q <= 1'b0; fired_q <= 1'b0; long_q <= 1'b0;
			end
			if (cmd.do_write) begin
				cursor_q <= cursor_q + PtrW'(1);
				if (fill_q < FillW'(LongWindow)) fill_q <= fill_q + FillW'(1);
			end
			if (cmd.do_clear) begin
				cursor_q <= '0; fill_q <= '0;
			end
			if (cmd.do_apply && {1'b0, item_q.requested_tier} < {1'b0, count_q} &&
				item_q.requested_tier != tier_q) begin
				tier_q <= item_q.requested_tier;
				switch_q <= switch_q + 32'd1;
				cursor_q <= '0; fill_q <= '0;
			end
			if (cmd.sel_start) begin
				long_q <= cmd.sel_long;
				found_q <= 1'b0;
			end
			if (cmd.sel_cmp && !phase_cap_q && last_scan && lt_n < rank && le_n >= rank)
				found_q <= 1'b1;
			if (cmd.decide) begin
				found_q <= 1'b0;
				if (!long_q) begin
					// short pass done, long pass may follow if it wanted no switch
					fired_q <= 1'b1;
					if (pct_q > down_q) want_q <= 1'b1;
				end else begin
					if (pct_q < up_q) want_q <= 1'b1;
					long_q <= 1'b1;
				end
			end
		end
	end

	// selection datapath: candidate j, scan all i, count v[i]<v[j] and v[i]<=v[j]
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pct_q <= '0; prop_q <= '0;
		end
		if (cmd.sel_start) begin
			cand_q <= cursor_q - (cmd.sel_long ? PtrW'(LongWindow) : PtrW'(ShortWindow));
			scan_q <= cursor_q - (cmd.sel_long ? PtrW'(LongWindow) : PtrW'(ShortWindow));
			scan_n_q <= '0; lt_q <= '0; le_q <= '0;
		end
		if (cmd.sel_cmp) begin
			if (phase_cap_q) begin
				cval_q <= rd_q;
			end else if (last_scan) begin
				if (lt_n < rank && le_n >= rank) begin
					pct_q <= cval_q;
				end
				cand_q <= cand_q + PtrW'(1);
				scan_q <= win_base;
				scan_n_q <= '0; lt_q <= '0; le_q <= '0;
			end else begin
				lt_q <= lt_n; le_q <= le_n;
				scan_q <= scan_q + PtrW'(1);
				scan_n_q <= scan_n_q + CntW'(1);
			end
		end
		if (cmd.decide) begin
			if (!long_q && pct_q > down_q) prop_q <= tier_q + 2'd1;
			if (long_q && pct_q < up_q) prop_q <= tier_q - 2'd1;
		end
	end

	// candidate value capture phase: after start or after advancing candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) phase_cap_q <= 1'b0;
		else if (cmd.sel_start) phase_cap_q <= 1'b1;
		else if (cmd.sel_cmp && phase_cap_q) phase_cap_q <= 1'b0;
		else if (cmd.sel_cmp && last_scan) phase_cap_q <= 1'b1;
	end

	assign t_clip = (tier_q < count_q) ? tier_q : count_q - 2'd1;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.switch_wanted   <= want_q && item_q.action == ActSample;
			out_data.proposed_tier   <= (item_q.action == ActSample) ? prop_q : 2'd0;
			out_data.window_p95      <= (item_q.action == ActSample) ? pct_q : 23'd0;
			out_data.apply_ok        <= item_q.action == ActApply &&
				{1'b0, item_q.requested_tier} < {1'b0, count_q};
			out_data.active_tier     <= t_clip;
			out_data.tiers_available <= count_q;
			out_data.active_width    <= tw_q[t_clip];
			out_data.active_height   <= th_q[t_clip];
			out_data.switches_done   <= switch_q;
		end
		if (cmd.load_item) item_q <= in_data;
	end

	// ring fill never exceeds the window
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(LongWindow))
		else $error("ring fill overflow");
	// a tier count outside one to three is impossible
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd0)
		else $error("tier count zero");
	// a result is only loaded into an empty or draining register
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("result overwritten");
endmodule
